### rtl/lsm_pkg.sv
package lsm_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 48;
    localparam int TS_W         = 63;
    localparam int CH_W         = 3;
    localparam int NBUCKET      = 5;
    localparam int NDELAY       = 3;

    localparam logic [CNT_W-1:0] WARN_RESET = 32'd100000;
    localparam logic [CNT_W-1:0] EDGE_5MS   = 32'd5000;
    localparam logic [CNT_W-1:0] EDGE_10MS  = 32'd10000;
    localparam logic [CNT_W-1:0] EDGE_15MS  = 32'd15000;
    localparam logic [CNT_W-1:0] EDGE_20MS  = 32'd20000;

    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_WARN    = 2'd2;

    localparam logic [3:0] WORD_TOTAL   = 4'd0;
    localparam logic [3:0] WORD_VALID   = 4'd1;
    localparam logic [3:0] WORD_INVALID = 4'd2;
    localparam logic [3:0] WORD_BUCKET0 = 4'd3;
    localparam logic [3:0] WORD_BUCKET4 = 4'd7;
    localparam logic [3:0] WORD_AVG0    = 4'd8;
    localparam logic [3:0] WORD_LAST    = 4'd13;

    typedef struct packed {
        logic [CNT_W-1:0]                 total;
        logic [CNT_W-1:0]                 invalid;
        logic [NBUCKET-1:0][CNT_W-1:0]    bucket;
        logic [NDELAY-1:0][SUM_W-1:0]     sum;
        logic [NDELAY-1:0][CNT_W-1:0]     maxv;
    } row_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELAY,
        S_UPDATE,
        S_LOAD,
        S_DSTART,
        S_DWAIT,
        S_EMIT
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat32(input logic [TS_W-1:0] v);
        return (|v[TS_W-1:CNT_W]) ? {CNT_W{1'b1}} : v[CNT_W-1:0];
    endfunction

endpackage

### rtl/lsm_div.sv
module lsm_div
    import lsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  quotient
);

    localparam int CW = $clog2(SUM_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(SUM_W - 1);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg,  cnt_next;
    logic [SUM_W-1:0]  dq_reg,   dq_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]  dvs_reg,  dvs_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dq_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (!diff[CNT_W])
            begin
                rem_next = diff[CNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (|dq_reg[SUM_W-1:CNT_W]) ? {CNT_W{1'b1}} : dq_reg[CNT_W-1:0];

endmodule

### rtl/latency_statistics_monitor.sv
// Channel      Signals                                         Direction
// request      start, busy (out), kind, channel, *_time        in
// result       strobe, record_kind, sample_status, word_index, out
//              word_value, last
// config       cfg_wr_en, cfg_wr_data                          in
//
// A sample passes through memory read, delay compute and read-modify-write.
// A snapshot runs three 48-step divisions for the averages, then emits
// 14 words back to back.
// Reset clears every channel at once through per-channel valid bits.
// The receiver cannot stall; busy stays high until the last result is out.
module latency_statistics_monitor
    import lsm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [CH_W-1:0]   channel,
    input  logic [TS_W-1:0]   exposure_time,
    input  logic [TS_W-1:0]   send_time,
    input  logic [TS_W-1:0]   receive_time,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    output logic              strobe,
    output logic              record_kind,
    output logic [1:0]        sample_status,
    output logic [3:0]        word_index,
    output logic [CNT_W-1:0]  word_value,
    output logic              last
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMPW = 8;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   thr_reg;
    logic [CHANNELS-1:0] vld_reg;

    row_t               mem [CHANNELS];
    row_t               rd_reg;
    row_t               cur;
    row_t               upd;
    row_t               row_reg;
    logic               mem_we;

    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW+CH_W-1:0] addr_ext;
    logic               have_reg;
    logic [TS_W-1:0]    te_reg, ts_reg, tr_reg;

    logic               ok_reg;
    logic               warn_reg;
    logic [2:0]         bkt_reg;
    logic [NDELAY-1:0][CNT_W-1:0] dl_reg;
    logic [NDELAY-1:0][CNT_W-1:0] dl_c;
    logic [2:0]         bkt_c;

    logic [CNT_W-1:0]   vcnt_reg;
    logic [1:0]         sel_reg, sel_next;
    logic [NDELAY-1:0][CNT_W-1:0] avg_reg;
    logic [3:0]         wcnt_reg, wcnt_next;

    logic               div_start;
    logic               div_done;
    logic [CNT_W-1:0]   div_q;

    logic               o_stb_next, o_kind_next, o_last_next;
    logic [1:0]         o_stat_next;
    logic [3:0]         o_idx_next;
    logic [CNT_W-1:0]   o_val_next;
    logic               o_stb_reg, o_kind_reg, o_last_reg;
    logic [1:0]         o_stat_reg;
    logic [3:0]         o_idx_reg;
    logic [CNT_W-1:0]   o_val_reg;

    logic [SUM_W:0]     sum_add;
    logic [2:0]         bidx;
    logic [1:0]         didx;

    assign addr_ext = {{AW{1'b0}}, channel};
    assign rd_addr  = (state_reg == S_IDLE) ? addr_ext[AW-1:0] : addr_reg;
    assign busy     = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= upd;
        end
        rd_reg <= mem[rd_addr];
    end

    assign cur = vld_reg[addr_reg] ? rd_reg : '0;

    // delays
    always_comb
    begin
        dl_c[0] = sat32(ts_reg - te_reg);
        dl_c[1] = sat32(tr_reg - ts_reg);
        dl_c[2] = sat32(tr_reg - te_reg);
        priority if (dl_c[1] < EDGE_5MS)  bkt_c = 3'd0;
        else if (dl_c[1] < EDGE_10MS)     bkt_c = 3'd1;
        else if (dl_c[1] < EDGE_15MS)     bkt_c = 3'd2;
        else if (dl_c[1] < EDGE_20MS)     bkt_c = 3'd3;
        else                              bkt_c = 3'd4;
    end

    // read-modify-write of one channel row
    always_comb
    begin
        upd       = cur;
        sum_add   = '0;
        upd.total = sat_inc(cur.total);
        if (!ok_reg)
        begin
            upd.invalid = sat_inc(cur.invalid);
        end
        else
        begin
            for (int d = 0; d < NDELAY; d++)
            begin
                sum_add = {1'b0, cur.sum[d]} + {{(SUM_W-CNT_W+1){1'b0}}, dl_reg[d]};
                upd.sum[d] = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                if (dl_reg[d] > cur.maxv[d])
                begin
                    upd.maxv[d] = dl_reg[d];
                end
            end
            upd.bucket[bkt_reg] = sat_inc(cur.bucket[bkt_reg]);
        end
    end

    lsm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (row_reg.sum[sel_reg]),
        .divisor  (vcnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        wcnt_next   = wcnt_reg;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        o_stb_next  = 1'b0;
        o_kind_next = KIND_SAMPLE;
        o_stat_next = STATUS_OK;
        o_idx_next  = WORD_TOTAL;
        o_val_next  = '0;
        o_last_next = 1'b0;
        bidx        = 3'(wcnt_reg - WORD_BUCKET0);
        didx        = 2'((wcnt_reg - WORD_AVG0) >> 1);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (kind == KIND_SNAPSHOT) ? S_LOAD : S_DELAY;
                end
            end
            S_DELAY:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                mem_we      = have_reg;
                o_stb_next  = 1'b1;
                o_last_next = 1'b1;
                if (!ok_reg)
                begin
                    o_stat_next = STATUS_INVALID;
                end
                else
                begin
                    o_stat_next = warn_reg ? STATUS_WARN : STATUS_OK;
                    o_val_next  = dl_reg[2];
                end
                state_next = S_IDLE;
            end
            S_LOAD:
            begin
                sel_next   = '0;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    if (sel_reg == 2'(NDELAY - 1))
                    begin
                        wcnt_next  = WORD_TOTAL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_EMIT:
            begin
                o_stb_next  = 1'b1;
                o_kind_next = KIND_SNAPSHOT;
                o_idx_next  = wcnt_reg;
                priority if (wcnt_reg == WORD_TOTAL)   o_val_next = row_reg.total;
                else if (wcnt_reg == WORD_VALID)       o_val_next = vcnt_reg;
                else if (wcnt_reg == WORD_INVALID)     o_val_next = row_reg.invalid;
                else if (wcnt_reg <= WORD_BUCKET4)     o_val_next = row_reg.bucket[bidx];
                else if (!wcnt_reg[0])                 o_val_next = avg_reg[didx];
                else                                   o_val_next = row_reg.maxv[didx];
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == WORD_LAST)
                begin
                    o_last_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            thr_reg   <= WARN_RESET;
            vld_reg   <= '0;
            sel_reg   <= '0;
            wcnt_reg  <= '0;
            o_stb_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            wcnt_reg  <= wcnt_next;
            o_stb_reg <= o_stb_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            else if (state_reg == S_LOAD && have_reg)
            begin
                vld_reg[addr_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            addr_reg <= addr_ext[AW-1:0];
            have_reg <= ({{(CMPW-CH_W){1'b0}}, channel} < CMPW'(CHANNELS));
            te_reg   <= exposure_time;
            ts_reg   <= send_time;
            tr_reg   <= receive_time;
        end
        if (state_reg == S_DELAY)
        begin
            ok_reg   <= (te_reg != '0) && (ts_reg != '0) && (tr_reg != '0)
                        && (ts_reg >= te_reg) && (tr_reg >= ts_reg);
            dl_reg   <= dl_c;
            bkt_reg  <= bkt_c;
            warn_reg <= (dl_c[2] > thr_reg);
        end
        if (state_reg == S_LOAD)
        begin
            row_reg  <= have_reg ? cur : '0;
            vcnt_reg <= !have_reg ? '0 :
                        (cur.total >= cur.invalid) ? cur.total - cur.invalid : '0;
        end
        if (state_reg == S_DWAIT && div_done)
        begin
            avg_reg[sel_reg] <= (vcnt_reg == '0) ? '0 : div_q;
        end
        o_kind_reg <= o_kind_next;
        o_stat_reg <= o_stat_next;
        o_idx_reg  <= o_idx_next;
        o_val_reg  <= o_val_next;
        o_last_reg <= o_last_next;
    end

    assign strobe        = o_stb_reg;
    assign record_kind   = o_kind_reg;
    assign sample_status = o_stat_reg;
    assign word_index    = o_idx_reg;
    assign word_value    = o_val_reg;
    assign last          = o_last_reg;

endmodule
